/* rtl/core/twb_pkg.sv */
// Shared types, sizes and codes of the trie word-break checker.
package twb_pkg;
    localparam int NODES    = 4096;
    localparam int ALPHABET = 32;
    localparam int MAX_WORD = 64;

    localparam int NODE_W  = $clog2(NODES);
    localparam int SYM_W   = $clog2(ALPHABET);
    localparam int SLOT_W  = NODE_W + SYM_W;
    localparam int SLOTS   = NODES * ALPHABET;
    localparam int CNT_W   = $clog2(NODES + 1);
    localparam int LEN_W   = $clog2(MAX_WORD + 1);
    localparam int ADDR_W  = $clog2(MAX_WORD);
    localparam int PIECE_W = 7;
    localparam int ENTRY_W = NODE_W + 1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_LONG = 2'd2;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_IRD,
        S_IWR,
        S_CLR,
        S_ST,
        S_SB,
        S_RD,
        S_CH,
        S_UP,
        S_FRD,
        S_FIN
    } t_state;

    function automatic logic [SYM_W-1:0] sat_sym(input logic [4:0] sym);
        if (int'(sym) >= ALPHABET) begin
            return SYM_W'(ALPHABET - 1);
        end
        return SYM_W'(sym);
    endfunction
endpackage

/* rtl/core/twb_ram.sv */
// Generic simple dual-port RAM with registered read.
module twb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/core/trie_word_break_checker.sv */
// Top level: dictionary trie insert and word-break query sequencer.
//
//  channel   | ports                                  | handshake
//  ----------+----------------------------------------+----------------------------
//  request   | i_cmd, i_symbol, i_last                | start & !busy
//  result    | o_was_query, o_status,                 | o_valid, one cycle, no stall
//            | o_is_concatenated, o_pieces            |
//
//  After reset a clearing pass writes every child slot, with busy high. A query
//  symbol that is not last is only stored in the word buffer; an insert symbol
//  does a child read, then an update through the child RAM. A query's last symbol
//  first clears one piece entry per symbol, then per start reads the base piece
//  count and walks the trie (buffer read, child read, piece update), and last
//  reads the final piece entry. Results cannot be stalled.
module trie_word_break_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_cmd,
    input  logic [4:0]            i_symbol,
    input  logic                  i_last,
    output logic                  o_valid,
    output logic                  o_was_query,
    output logic [1:0]            o_status,
    output logic                  o_is_concatenated,
    output logic [6:0]            o_pieces
);
    import twb_pkg::*;

    t_state r_state, n_state;
    logic [SLOT_W-1:0]  r_clr, n_clr;
    logic [CNT_W-1:0]   r_nodes, n_nodes;
    logic [NODE_W-1:0]  r_cursor, n_cursor;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [1:0]         r_err, n_err;
    logic [SYM_W-1:0]   r_sym, n_sym;
    logic               r_last, n_last;
    logic [LEN_W-1:0]   r_start, n_start;
    logic [LEN_W-1:0]   r_idx, n_idx;
    logic [NODE_W-1:0]  r_node, n_node;
    logic [PIECE_W-1:0] r_base, n_base;
    logic               r_valid, n_valid;
    logic               r_wq, n_wq;
    logic [1:0]         r_status, n_status;
    logic [PIECE_W-1:0] r_pieces, n_pieces;

    logic               c_we, c_re;
    logic [SLOT_W-1:0]  c_waddr, c_raddr;
    logic [ENTRY_W-1:0] c_wdata, c_rdata;
    logic               w_we;
    logic [ADDR_W-1:0]  w_waddr;
    logic [SYM_W-1:0]   w_rdata;
    logic               p_we, p_re;
    logic [ADDR_W-1:0]  p_waddr, p_raddr;
    logic [PIECE_W-1:0] p_wdata, p_rdata;

    logic               accept;
    logic [SYM_W-1:0]   in_sym;
    logic [NODE_W-1:0]  child;
    logic [LEN_W-1:0]   start_m1, len_m1;
    logic [PIECE_W:0]   base_p1;

    assign accept   = start && (r_state == S_IDLE);
    assign in_sym   = sat_sym(i_symbol);
    assign child    = c_rdata[NODE_W-1:0];
    assign start_m1 = r_start - LEN_W'(1);
    assign len_m1   = r_len - LEN_W'(1);
    assign base_p1  = {1'b0, r_base} + (PIECE_W+1)'(1);

    twb_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_child (
        .i_clk(i_clk), .i_we(c_we), .i_waddr(c_waddr), .i_wdata(c_wdata),
        .i_re(c_re), .i_raddr(c_raddr), .o_rdata(c_rdata)
    );

    twb_ram #(.WIDTH(SYM_W), .DEPTH(MAX_WORD)) u_word (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(in_sym),
        .i_re(r_state == S_RD), .i_raddr(r_idx[ADDR_W-1:0]), .o_rdata(w_rdata)
    );

    twb_ram #(.WIDTH(PIECE_W), .DEPTH(MAX_WORD)) u_piece (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_waddr), .i_wdata(p_wdata),
        .i_re(p_re), .i_raddr(p_raddr), .o_rdata(p_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_clr    <= '0;
            r_nodes  <= CNT_W'(1);
            r_cursor <= '0;
            r_len    <= '0;
            r_err    <= ST_OK;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_nodes  <= n_nodes;
            r_cursor <= n_cursor;
            r_len    <= n_len;
            r_err    <= n_err;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym    <= n_sym;
        r_last   <= n_last;
        r_start  <= n_start;
        r_idx    <= n_idx;
        r_node   <= n_node;
        r_base   <= n_base;
        r_wq     <= n_wq;
        r_status <= n_status;
        r_pieces <= n_pieces;
    end

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_nodes  = r_nodes;
        n_cursor = r_cursor;
        n_len    = r_len;
        n_err    = r_err;
        n_sym    = r_sym;
        n_last   = r_last;
        n_start  = r_start;
        n_idx    = r_idx;
        n_node   = r_node;
        n_base   = r_base;
        n_valid  = 1'b0;
        n_wq     = r_wq;
        n_status = r_status;
        n_pieces = r_pieces;
        c_we     = 1'b0;
        c_waddr  = {r_cursor, r_sym};
        c_wdata  = '0;
        c_re     = 1'b0;
        c_raddr  = {r_cursor, r_sym};
        w_we     = 1'b0;
        w_waddr  = r_len[ADDR_W-1:0];
        p_we     = 1'b0;
        p_waddr  = r_idx[ADDR_W-1:0];
        p_wdata  = '0;
        p_re     = 1'b0;
        p_raddr  = r_idx[ADDR_W-1:0];

        case (r_state)
            S_INIT: begin
                c_we    = 1'b1;
                c_waddr = r_clr;
                n_clr   = r_clr + SLOT_W'(1);
                if (r_clr == SLOT_W'(SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_sym  = in_sym;
                    n_last = i_last;
                    if (int'(r_len) >= MAX_WORD) begin
                        if (r_err == ST_OK) begin
                            n_err = ST_LONG;
                        end
                    end else begin
                        w_we  = 1'b1;
                        n_len = r_len + LEN_W'(1);
                    end
                    if (int'(r_len) < MAX_WORD && i_cmd == CMD_INSERT
                            && r_err == ST_OK) begin
                        n_state = S_IRD;
                    end else if (i_last) begin
                        if (i_cmd == CMD_QUERY && n_err == ST_OK) begin
                            n_idx   = '0;
                            n_state = S_CLR;
                        end else begin
                            n_valid  = 1'b1;
                            n_wq     = i_cmd;
                            n_status = n_err;
                            n_pieces = '0;
                            n_len    = '0;
                            n_err    = ST_OK;
                            n_cursor = '0;
                        end
                    end
                end
            end
            S_IRD: begin
                c_re    = 1'b1;
                n_state = S_IWR;
            end
            S_IWR: begin
                n_state = S_IDLE;
                if (child == '0) begin
                    if (r_nodes >= CNT_W'(NODES)) begin
                        n_err = ST_FULL;
                    end else begin
                        c_we     = 1'b1;
                        c_wdata  = {r_last, r_nodes[NODE_W-1:0]};
                        n_cursor = r_nodes[NODE_W-1:0];
                        n_nodes  = r_nodes + CNT_W'(1);
                    end
                end else begin
                    n_cursor = child;
                    if (r_last) begin
                        c_we    = 1'b1;
                        c_wdata = {1'b1, child};
                    end
                end
                if (r_last) begin
                    n_valid  = 1'b1;
                    n_wq     = CMD_INSERT;
                    n_status = n_err;
                    n_pieces = '0;
                    n_len    = '0;
                    n_err    = ST_OK;
                    n_cursor = '0;
                end
            end
            S_CLR: begin
                p_we  = 1'b1;
                n_idx = r_idx + LEN_W'(1);
                if (n_idx == r_len) begin
                    n_start = '0;
                    n_state = S_ST;
                end
            end
            S_ST: begin
                if (r_start == r_len) begin
                    n_state = S_FRD;
                end else if (r_start == '0) begin
                    n_base  = '0;
                    n_node  = '0;
                    n_idx   = '0;
                    n_state = S_RD;
                end else begin
                    p_re    = 1'b1;
                    p_raddr = start_m1[ADDR_W-1:0];
                    n_state = S_SB;
                end
            end
            S_SB: begin
                n_base = p_rdata;
                if (p_rdata == '0) begin
                    n_start = r_start + LEN_W'(1);
                    n_state = S_ST;
                end else begin
                    n_node  = '0;
                    n_idx   = r_start;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                p_re    = 1'b1;
                n_state = S_CH;
            end
            S_CH: begin
                c_re    = 1'b1;
                c_raddr = {r_node, w_rdata};
                n_state = S_UP;
            end
            S_UP: begin
                if (child == '0) begin
                    n_start = r_start + LEN_W'(1);
                    n_state = S_ST;
                end else begin
                    n_node = child;
                    if (c_rdata[NODE_W] && {1'b0, p_rdata} < base_p1) begin
                        p_we    = 1'b1;
                        p_wdata = base_p1[PIECE_W-1:0];
                    end
                    n_idx = r_idx + LEN_W'(1);
                    if (n_idx == r_len) begin
                        n_start = r_start + LEN_W'(1);
                        n_state = S_ST;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_FRD: begin
                p_re    = 1'b1;
                p_raddr = len_m1[ADDR_W-1:0];
                n_state = S_FIN;
            end
            S_FIN: begin
                n_valid  = 1'b1;
                n_wq     = CMD_QUERY;
                n_status = ST_OK;
                n_pieces = p_rdata;
                n_len    = '0;
                n_err    = ST_OK;
                n_cursor = '0;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy              = (r_state != S_IDLE);
    assign o_valid           = r_valid;
    assign o_was_query       = r_wq;
    assign o_status          = r_status;
    assign o_is_concatenated = (r_pieces > PIECE_W'(1));
    assign o_pieces          = r_pieces;
endmodule

/* rtl/core/twb_checker.sv */
// Port-level assertions for the trie word-break checker, with bind.
module twb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       o_was_query,
    input logic [1:0] o_status,
    input logic       o_is_concatenated,
    input logic [6:0] o_pieces
);
    import twb_pkg::*;

    a_spaced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("results back to back");

    a_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_was_query == CMD_INSERT) |-> (o_pieces == 7'd0 && !o_is_concatenated))
        else $error("insert result carries pieces");

    a_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> o_pieces == 7'd0)
        else $error("error result carries pieces");

    a_concat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_is_concatenated == (o_pieces > 7'd1)))
        else $error("concatenated flag disagrees with pieces");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK || o_status == ST_FULL || o_status == ST_LONG))
        else $error("undefined status code");
endmodule

bind trie_word_break_checker twb_checker u_twb_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .o_valid(o_valid),
    .o_was_query(o_was_query),
    .o_status(o_status),
    .o_is_concatenated(o_is_concatenated),
    .o_pieces(o_pieces)
);

/* dv/tb_top.sv */
// Testbench for the trie word-break checker: directed table, random words, predictor check.
`timescale 1ns / 100ps
module tb_top;
    import twb_pkg::*;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic       i_cmd = CMD_INSERT;
    logic [4:0] i_symbol = '0;
    logic       i_last = 1'b0;
    logic       o_valid;
    logic       o_was_query;
    logic [1:0] o_status;
    logic       o_is_concatenated;
    logic [6:0] o_pieces;

    trie_word_break_checker dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cmd(i_cmd), .i_symbol(i_symbol), .i_last(i_last),
        .o_valid(o_valid), .o_was_query(o_was_query), .o_status(o_status),
        .o_is_concatenated(o_is_concatenated), .o_pieces(o_pieces)
    );

    always #4 i_clk = ~i_clk;

    typedef struct packed {
        logic       was_query;
        logic [1:0] status;
        logic       concat;
        logic [6:0] pieces;
    } t_answer;

    typedef struct {
        logic       cmd;
        logic [4:0] sym;
        logic       last;
        logic       fixed;
        t_answer    ans;
    } t_row;

    // predictor state
    int      trie_kids[int];
    bit      word_end[NODES];
    int      node_count;
    int      cursor;
    int      word_syms[MAX_WORD];
    int      word_len;
    int      word_err;
    t_answer answers_q[$];
    t_answer fixed_q[$];
    bit      fixed_flag_q[$];

    int  errors = 0;
    int  cycles = 0;
    int  n_ins = 0, n_qry = 0, n_cat = 0, n_full = 0, n_long = 0;

    function automatic int kid(int node, int sym);
        int k;
        k = node * ALPHABET + sym;
        return trie_kids.exists(k) ? trie_kids[k] : 0;
    endfunction

    function automatic int count_pieces(int n);
        int best[MAX_WORD];
        int node, nxt, base;
        for (int i = 0; i < n; i++) best[i] = 0;
        for (int s = 0; s < n; s++) begin
            if (s != 0 && best[s-1] == 0) continue;
            base = (s == 0) ? 0 : best[s-1];
            node = 0;
            for (int i = s; i < n; i++) begin
                nxt = kid(node, word_syms[i]);
                if (nxt == 0) break;
                node = nxt;
                if (word_end[node] && best[i] < base + 1) best[i] = base + 1;
            end
        end
        return best[n-1];
    endfunction

    function automatic void predict_request(logic cmd, logic [4:0] sym_in, logic last,
                                            output bit has, output t_answer a);
        int sym, nxt, p;
        sym = (int'(sym_in) >= ALPHABET) ? ALPHABET - 1 : int'(sym_in);
        has = 0;
        a = '0;
        if (word_len >= MAX_WORD) begin
            if (word_err == 0) word_err = ST_LONG;
        end else begin
            word_syms[word_len] = sym;
            word_len++;
            if (cmd == CMD_INSERT && word_err == 0) begin
                nxt = kid(cursor, sym);
                if (nxt == 0) begin
                    if (node_count >= NODES) word_err = ST_FULL;
                    else begin
                        nxt = node_count;
                        node_count++;
                        trie_kids[cursor * ALPHABET + sym] = nxt;
                    end
                end
                if (word_err == 0) cursor = nxt;
            end
        end
        if (!last) return;
        has = 1;
        a.was_query = cmd;
        a.status = word_err[1:0];
        if (cmd == CMD_INSERT) begin
            if (word_err == 0) word_end[cursor] = 1;
        end else if (word_err == 0 && word_len > 0) begin
            p = count_pieces(word_len);
            a.concat = p > 1;
            a.pieces = (p > 127) ? 7'd127 : p[6:0];
        end
        cursor = 0;
        word_len = 0;
        word_err = 0;
    endfunction

    // monitor: requests and results at rising edge
    always @(posedge i_clk) begin
        bit has;
        t_answer a, got, exp;
        if (i_rst_n) begin
            cycles++;
            if (start && !busy) begin
                predict_request(i_cmd, i_symbol, i_last, has, a);
                if (has) answers_q.insert(answers_q.size(), a);
            end
            if (o_valid) begin
                got = '{o_was_query, o_status, o_is_concatenated, o_pieces};
                if (answers_q.size() == 0) begin
                    $error("result with no request pending");
                    errors++;
                end else begin
                    exp = answers_q.pop_front();
                    if (fixed_flag_q.size() > 0) begin
                        if (fixed_flag_q.pop_front()) begin
                            t_answer f;
                            f = fixed_q.pop_front();
                            if (f !== exp) begin
                                $error("table row %h disagrees with predictor %h", f, exp);
                                errors++;
                            end
                        end
                    end
                    if (got.was_query !== exp.was_query) begin
                        $error("was_query exp %0d got %0d", exp.was_query, got.was_query);
                        errors++;
                    end
                    if (got.status !== exp.status) begin
                        $error("status exp %0d got %0d", exp.status, got.status);
                        errors++;
                    end
                    if (got.concat !== exp.concat) begin
                        $error("is_concatenated exp %0d got %0d", exp.concat, got.concat);
                        errors++;
                    end
                    if (got.pieces !== exp.pieces) begin
                        $error("pieces exp %0d got %0d", exp.pieces, got.pieces);
                        errors++;
                    end
                    if (exp.was_query) n_qry++; else n_ins++;
                    if (exp.concat) n_cat++;
                    if (exp.status == ST_FULL) n_full++;
                    if (exp.status == ST_LONG) n_long++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > 20000000) begin
            $display("trie_word_break_checker test failed");
            $finish;
        end
    end

    int burst_left = 0;

    task automatic send(logic cmd, logic [4:0] sym, logic last);
        if (burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0) @(negedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        start <= 1'b1;
        i_cmd <= cmd;
        i_symbol <= sym;
        i_last <= last;
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_word(logic cmd, int syms[$]);
        for (int i = 0; i < syms.size(); i++)
            send(cmd, syms[i][4:0], i == syms.size() - 1);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (answers_q.size() != 0) @(negedge i_clk);
        repeat (3 * MAX_WORD * (MAX_WORD + 1) / 2 + 400) @(negedge i_clk);
    endtask

    int dict[$][$];

    function automatic void pick_word(output int w[$], input int len, input int alpha);
        w = {};
        for (int i = 0; i < len; i++) w.insert(w.size(), int'($urandom_range(0, alpha - 1)));
    endfunction

    t_row rows[$];

    task automatic add_row(logic cmd, logic [4:0] sym, logic last, logic fixed,
                           t_answer ans);
        t_row r;
        r.cmd = cmd; r.sym = sym; r.last = last; r.fixed = fixed; r.ans = ans;
        rows.insert(rows.size(), r);
    endtask

    initial begin
        int w[$], a[$], b[$], q[$];
        int n, k;
        node_count = 1; cursor = 0; word_len = 0; word_err = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table
        add_row(CMD_QUERY, 5'd0, 1'b1, 1'b1, '{1'b1, ST_OK, 1'b0, 7'd0});
        add_row(CMD_INSERT, 5'd0, 1'b1, 1'b1, '{1'b0, ST_OK, 1'b0, 7'd0});
        add_row(CMD_INSERT, 5'd31, 1'b1, 1'b1, '{1'b0, ST_OK, 1'b0, 7'd0});
        add_row(CMD_QUERY, 5'd0, 1'b0, 1'b0, '0);
        add_row(CMD_QUERY, 5'd31, 1'b0, 1'b0, '0);
        add_row(CMD_QUERY, 5'd0, 1'b1, 1'b1, '{1'b1, ST_OK, 1'b1, 7'd3});
        add_row(CMD_QUERY, 5'd31, 1'b1, 1'b1, '{1'b1, ST_OK, 1'b0, 7'd1});
        add_row(CMD_INSERT, 5'd5, 1'b0, 1'b0, '0);
        add_row(CMD_INSERT, 5'd10, 1'b1, 1'b0, '0);
        add_row(CMD_QUERY, 5'd5, 1'b0, 1'b0, '0);
        add_row(CMD_QUERY, 5'd10, 1'b0, 1'b0, '0);
        add_row(CMD_QUERY, 5'd0, 1'b1, 1'b0, '0);
        add_row(CMD_QUERY, 5'd5, 1'b0, 1'b0, '0);   // mixed: query then insert last
        add_row(CMD_INSERT, 5'd21, 1'b1, 1'b0, '0);
        foreach (rows[i]) begin
            if (rows[i].last) begin
                fixed_flag_q.insert(fixed_flag_q.size(), rows[i].fixed);
                if (rows[i].fixed) fixed_q.insert(fixed_q.size(), rows[i].ans);
            end
            send(rows[i].cmd, rows[i].sym, rows[i].last);
        end
        // over-long query then insert, 64 zeros gives the largest piece count
        for (int i = 0; i < MAX_WORD; i++) send(CMD_QUERY, 5'd0, i == MAX_WORD - 1);
        for (int i = 0; i <= MAX_WORD; i++) send(CMD_QUERY, 5'd0, i == MAX_WORD);
        for (int i = 0; i <= MAX_WORD + 2; i++) send(CMD_INSERT, 5'd7, i == MAX_WORD + 2);
        drain();

        // random: build a dictionary of short words, query concatenations, send random requests
        for (int it = 0; it < 130; it++) begin
            k = $urandom_range(0, 9);
            if (k < 3 || dict.size() == 0) begin
                pick_word(w, $urandom_range(1, 4), $urandom_range(0, 1) ? 4 : 32);
                dict.insert(dict.size(), w);
                send_word(CMD_INSERT, w);
            end else if (k < 8) begin
                q = {};
                n = $urandom_range(1, 5);
                for (int j = 0; j < n; j++) begin
                    a = dict[$urandom_range(0, dict.size() - 1)];
                    foreach (a[m]) if (q.size() < MAX_WORD) q.insert(q.size(), a[m]);
                end
                if ($urandom_range(0, 5) == 0) q[$urandom_range(0, q.size() - 1)] =
                    $urandom_range(0, 31);
                send_word(CMD_QUERY, q);
            end else begin
                n = $urandom_range(1, 6);
                for (int j = 0; j < n; j++)
                    send(1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)), j == n - 1);
            end
            if (it == 65) drain();
        end
        drain();

        // pairs of dictionary words, then the first dictionary word inserted again
        for (int it = 0; it < 40; it++) begin
            a = dict[$urandom_range(0, dict.size() - 1)];
            b = dict[$urandom_range(0, dict.size() - 1)];
            q = {a, b};
            send_word(CMD_QUERY, q);
        end
        send_word(CMD_INSERT, dict[0]);
        drain();

        $display("covered %0d insert and %0d query answers, %0d concatenated,",
                 n_ins, n_qry, n_cat);
        $display("%0d table-full and %0d over-long words", n_full, n_long);
        if (errors == 0 && answers_q.size() == 0) begin
            $display("trie_word_break_checker test passed");
        end else begin
            $display("trie_word_break_checker test failed");
        end
        $finish;
    end
endmodule

/* sim.f */
rtl/core/twb_pkg.sv
rtl/core/twb_ram.sv
rtl/core/trie_word_break_checker.sv
rtl/core/twb_checker.sv
dv/tb_top.sv
